/* hw/rtl/jsu_pkg.sv */
// Shared types, codes and helpers for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpW      = 16;
  localparam int unsigned MaxBytes = 3;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_CONT    = 3'd0,
    ST_DONE    = 3'd1,
    ST_BAD_U   = 3'd2,
    ST_BAD_ESC = 3'd3,
    ST_UNTERM  = 3'd4
  } status_e;

  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash     = 8'h2F;
  localparam logic [ByteW-1:0] ChLowerN    = 8'h6E;
  localparam logic [ByteW-1:0] ChLowerT    = 8'h74;
  localparam logic [ByteW-1:0] ChLowerR    = 8'h72;
  localparam logic [ByteW-1:0] ChLowerB    = 8'h62;
  localparam logic [ByteW-1:0] ChLowerF    = 8'h66;
  localparam logic [ByteW-1:0] ChLowerU    = 8'h75;

  localparam logic [ByteW-1:0] CtlLf = 8'h0A;
  localparam logic [ByteW-1:0] CtlHt = 8'h09;
  localparam logic [ByteW-1:0] CtlCr = 8'h0D;
  localparam logic [ByteW-1:0] CtlBs = 8'h08;
  localparam logic [ByteW-1:0] CtlFf = 8'h0C;

  localparam logic [ByteW-1:0] Utf8Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Utf8Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Utf8Cont  = 8'h80;
  localparam logic [CpW-1:0]   CpLim1    = 16'h0080;
  localparam logic [CpW-1:0]   CpLim2    = 16'h0800;

  // Group of results caused by one input word.
  typedef struct packed {
    logic [1:0]                     cnt;
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic                           data_vld;
    status_e                        status;
  } grp_t;

  // Non-hex characters count as zero.
  function automatic logic [3:0] hex_digit(input logic [ByteW-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

endpackage

/* hw/rtl/jsu_decode.sv */
// Escape state machine: mode and code point registers plus per-word result group.
`timescale 1ns / 1ps

module jsu_decode
  import jsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             func_i,
  input  logic [ByteW-1:0] in_byte_i,
  output grp_t             grp_o
);

  mode_e          mode_q, mode_d;
  logic [CpW-1:0] acc_q, acc_d;
  logic [CpW-1:0] cp;
  logic           in_hex;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

  assign cp     = {acc_q[CpW-5:0], hex_digit(in_byte_i)};
  assign in_hex = (mode_q == MODE_HEX0) || (mode_q == MODE_HEX1) ||
                  (mode_q == MODE_HEX2) || (mode_q == MODE_HEX3);

  always_comb begin
    mode_d         = mode_q;
    acc_d          = acc_q;
    grp_o.cnt      = 2'd0;
    grp_o.bytes    = '0;
    grp_o.data_vld = 1'b1;
    grp_o.status   = ST_CONT;

    if (func_i) begin
      mode_d         = MODE_NORMAL;
      acc_d          = '0;
      grp_o.cnt      = 2'd1;
      grp_o.data_vld = 1'b0;
      grp_o.status   = in_hex ? ST_BAD_U : ST_UNTERM;
    end else begin
      unique case (mode_q)
        MODE_ESCAPE: begin
          mode_d    = MODE_NORMAL;
          grp_o.cnt = 2'd1;
          unique case (in_byte_i)
            ChQuote:     grp_o.bytes[0] = ChQuote;
            ChBackslash: grp_o.bytes[0] = ChBackslash;
            ChSlash:     grp_o.bytes[0] = ChSlash;
            ChLowerN:    grp_o.bytes[0] = CtlLf;
            ChLowerT:    grp_o.bytes[0] = CtlHt;
            ChLowerR:    grp_o.bytes[0] = CtlCr;
            ChLowerB:    grp_o.bytes[0] = CtlBs;
            ChLowerF:    grp_o.bytes[0] = CtlFf;
            ChLowerU: begin
              mode_d    = MODE_HEX0;
              acc_d     = '0;
              grp_o.cnt = 2'd0;
            end
            default: begin
              acc_d          = '0;
              grp_o.data_vld = 1'b0;
              grp_o.status   = ST_BAD_ESC;
            end
          endcase
        end
        MODE_HEX0: begin
          acc_d  = cp;
          mode_d = MODE_HEX1;
        end
        MODE_HEX1: begin
          acc_d  = cp;
          mode_d = MODE_HEX2;
        end
        MODE_HEX2: begin
          acc_d  = cp;
          mode_d = MODE_HEX3;
        end
        MODE_HEX3: begin
          mode_d = MODE_NORMAL;
          acc_d  = '0;
          if (cp < CpLim1) begin
            grp_o.cnt      = 2'd1;
            grp_o.bytes[0] = cp[ByteW-1:0];
          end else if (cp < CpLim2) begin
            grp_o.cnt      = 2'd2;
            grp_o.bytes[0] = Utf8Lead2 | {3'd0, cp[10:6]};
            grp_o.bytes[1] = Utf8Cont | {2'd0, cp[5:0]};
          end else begin
            grp_o.cnt      = 2'd3;
            grp_o.bytes[0] = Utf8Lead3 | {4'd0, cp[15:12]};
            grp_o.bytes[1] = Utf8Cont | {2'd0, cp[11:6]};
            grp_o.bytes[2] = Utf8Cont | {2'd0, cp[5:0]};
          end
        end
        default: begin
          mode_d    = MODE_NORMAL;
          grp_o.cnt = 2'd1;
          if (in_byte_i == ChQuote) begin
            acc_d          = '0;
            grp_o.data_vld = 1'b0;
            grp_o.status   = ST_DONE;
          end else if (in_byte_i == ChBackslash) begin
            mode_d    = MODE_ESCAPE;
            grp_o.cnt = 2'd0;
          end else begin
            grp_o.bytes[0] = in_byte_i;
          end
        end
      endcase
    end
  end

endmodule

/* hw/rtl/jsu_outq.sv */
// Result register: holds one result group and hands it out one word per cycle while res_ready_i is high.
`timescale 1ns / 1ps

module jsu_outq
  import jsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  grp_t             grp_i,
  output logic             can_take_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_valid_o,
  output logic [2:0]       status_o,
  output logic             last_of_run_o
);

  grp_t       grp_q;
  logic       full_q;
  logic [1:0] idx_q;
  logic       pop;
  logic       last;

  assign last        = (idx_q == grp_q.cnt - 2'd1);
  assign pop         = full_q && res_ready_i;
  assign can_take_o  = !full_q || (pop && last);
  assign res_valid_o = full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      full_q <= 1'b1;
      idx_q  <= '0;
    end else if (pop && last) begin
      full_q <= 1'b0;
    end else if (pop) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

  assign out_byte_o    = grp_q.bytes[idx_q];
  assign out_valid_o   = grp_q.data_vld;
  assign status_o      = grp_q.status;
  assign last_of_run_o = last;

endmodule

/* hw/rtl/json_string_unescape.sv */
// Top level of the streaming JSON string body unescaper.
//
// Input channel: in_valid_i / in_ready_o carry one word: func_i (0 = text
// byte in in_byte_i, 1 = end of text). Output channel: res_valid_o /
// res_ready_i carry one result word: out_byte_o, out_valid_o, status_o,
// last_of_run_o.
// A backslash opening an escape, the u of a \u escape and its first three hex
// digits give no result. Every other input word gives one result group of 1 to
// 3 words, loaded into the result register at the edge that accepts the word.
// Throughput: one input word per cycle while groups are single words and the
// receiver does not stall; a group of more than one word holds the result
// register until its last word leaves, such as a 3-byte UTF-8 code point.
// A new word is taken in the same cycle the last word of the current group
// leaves. When the receiver stalls, the result register holds and the
// input stalls while it is full, words with no result included.
// Reset clears the escape state and the code point register and empties the
// result register; the block is ready as soon as reset is released.
// After a done or error status the block is ready for the next string.
`timescale 1ns / 1ps

module json_string_unescape
  import jsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             func_i,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_valid_o,
  output logic [2:0]       status_o,
  output logic             last_of_run_o
);

  logic accept;
  grp_t grp;

  assign accept = in_valid_i && in_ready_o;

  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (func_i),
    .in_byte_i(in_byte_i),
    .grp_o    (grp)
  );

  jsu_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept && (grp.cnt != 2'd0)),
    .grp_i        (grp),
    .can_take_o   (in_ready_o),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_byte_o   (out_byte_o),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

/* hw/rtl/jsu_checker.sv */
// Port-level assertions for the unescaper and the bind that attaches them.
`timescale 1ns / 1ps

module jsu_assertions
  import jsu_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             func_i,
  input logic [ByteW-1:0] in_byte_i,
  input logic             res_valid_o,
  input logic             res_ready_i,
  input logic [ByteW-1:0] out_byte_o,
  input logic             out_valid_o,
  input logic [2:0]       status_o,
  input logic             last_of_run_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(func_i) && $stable(in_byte_i))
    else $error("input word changed while waiting");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(out_byte_o) &&
    $stable(status_o) && $stable(last_of_run_o))
    else $error("result word changed while stalled");

  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> last_of_run_o && (out_byte_o == '0) &&
    (status_o != ST_CONT))
    else $error("status word malformed");

  a_data_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> (status_o == ST_CONT))
    else $error("data word with terminal status");

  a_run_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && !last_of_run_o |=> res_valid_o && out_valid_o &&
    (out_byte_o[7:6] == 2'b10))
    else $error("multi-byte run broken");

endmodule

bind json_string_unescape jsu_assertions u_jsu_assertions (.*);

/* tb/jsu_checker.sv */
// Scoreboard for the JSON string unescaper: predicts result words and checks them.
`timescale 1ns / 1ps

module jsu_checker
  import jsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             func_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             res_valid_i,
  input  logic             res_ready_i,
  input  logic [ByteW-1:0] out_byte_i,
  input  logic             out_valid_i,
  input  logic [2:0]       status_i,
  input  logic             last_of_run_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             data_vld;
    status_e          status;
    logic             last;
  } res_word_t;

  res_word_t      want_q[$];
  mode_e          mode_q;
  logic [CpW-1:0] cp_q;

  function automatic logic [3:0] nibble(input logic [ByteW-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) return 4'(c[3:0] + 4'd9);
    return 4'd0;
  endfunction

  task automatic emit(input logic [ByteW-1:0] d, input logic v, input status_e s,
                      input logic l);
    res_word_t w;
    w.data     = d;
    w.data_vld = v;
    w.status   = s;
    w.last     = l;
    want_q = {want_q, w};
  endtask

  task automatic close_string(input status_e s);
    mode_q = MODE_NORMAL;
    cp_q   = '0;
    emit(8'h00, 1'b0, s, 1'b1);
  endtask

  task automatic predict(input logic f, input logic [ByteW-1:0] c);
    logic [CpW-1:0] cp;
    cp = {cp_q[11:0], nibble(c)};
    if (f) begin
      case (mode_q)
        MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: close_string(ST_BAD_U);
        default: close_string(ST_UNTERM);
      endcase
    end else begin
      case (mode_q)
        MODE_ESCAPE: begin
          mode_q = MODE_NORMAL;
          case (c)
            ChQuote, ChBackslash, ChSlash: emit(c, 1'b1, ST_CONT, 1'b1);
            ChLowerN: emit(CtlLf, 1'b1, ST_CONT, 1'b1);
            ChLowerT: emit(CtlHt, 1'b1, ST_CONT, 1'b1);
            ChLowerR: emit(CtlCr, 1'b1, ST_CONT, 1'b1);
            ChLowerB: emit(CtlBs, 1'b1, ST_CONT, 1'b1);
            ChLowerF: emit(CtlFf, 1'b1, ST_CONT, 1'b1);
            ChLowerU: begin
              mode_q = MODE_HEX0;
              cp_q   = '0;
            end
            default: close_string(ST_BAD_ESC);
          endcase
        end
        MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
          cp_q   = cp;
          mode_q = mode_e'(mode_q + 3'd1);
        end
        MODE_HEX3: begin
          mode_q = MODE_NORMAL;
          cp_q   = '0;
          if (cp < 16'h0080) begin
            emit(cp[7:0], 1'b1, ST_CONT, 1'b1);
          end else if (cp < 16'h0800) begin
            emit({3'b110, cp[10:6]}, 1'b1, ST_CONT, 1'b0);
            emit({2'b10, cp[5:0]}, 1'b1, ST_CONT, 1'b1);
          end else begin
            emit({4'b1110, cp[15:12]}, 1'b1, ST_CONT, 1'b0);
            emit({2'b10, cp[11:6]}, 1'b1, ST_CONT, 1'b0);
            emit({2'b10, cp[5:0]}, 1'b1, ST_CONT, 1'b1);
          end
        end
        default: begin
          mode_q = MODE_NORMAL;
          if (c == ChQuote) close_string(ST_DONE);
          else if (c == ChBackslash) mode_q = MODE_ESCAPE;
          else emit(c, 1'b1, ST_CONT, 1'b1);
        end
      endcase
    end
  endtask

  task automatic flag(input string what);
    errors_o++;
    if (errors_o <= 10) $display("%0t mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_word_t want;
    if (!rst_ni) begin
      want_q.delete();
      mode_q    = MODE_NORMAL;
      cp_q      = '0;
      errors_o  = 0;
      pending_o = 0;
      results_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict(func_i, in_byte_i);
      if (res_valid_i && res_ready_i) begin
        results_o++;
        if (want_q.size() == 0) begin
          flag($sformatf("unexpected word byte=%02h vld=%0b st=%0d last=%0b",
                         out_byte_i, out_valid_i, status_i, last_of_run_i));
        end else begin
          want = want_q.pop_front();
          if (out_byte_i !== want.data || out_valid_i !== want.data_vld ||
              status_i !== want.status || last_of_run_i !== want.last)
            flag($sformatf({"exp byte=%02h vld=%0b st=%0d last=%0b, ",
                            "got byte=%02h vld=%0b st=%0d last=%0b"},
                           want.data, want.data_vld, want.status, want.last,
                           out_byte_i, out_valid_i, status_i, last_of_run_i));
        end
      end
      pending_o = want_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the unescaper testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import jsu_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int RandomWords = 310;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             func;
  logic [ByteW-1:0] in_byte;
  logic             res_valid;
  logic             res_ready;
  logic [ByteW-1:0] out_byte;
  logic             out_valid;
  logic [2:0]       status;
  logic             last_of_run;

  int errors;
  int pending;
  int results;
  int words_sent;
  int strings_sent;
  int directed_words;
  bit calm;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  json_string_unescape dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .in_byte_i    (in_byte),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .out_byte_o   (out_byte),
    .out_valid_o  (out_valid),
    .status_o     (status),
    .last_of_run_o(last_of_run)
  );

  jsu_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .func_i       (func),
    .in_byte_i    (in_byte),
    .res_valid_i  (res_valid),
    .res_ready_i  (res_ready),
    .out_byte_i   (out_byte),
    .out_valid_i  (out_valid),
    .status_i     (status),
    .last_of_run_i(last_of_run),
    .errors_o     (errors),
    .pending_o    (pending),
    .results_o    (results)
  );

  // mostly short gaps, a few long ones; none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ByteW-1:0] esc_char(input int i);
    case (i)
      0: return ChQuote;
      1: return ChBackslash;
      2: return ChSlash;
      3: return ChLowerN;
      4: return ChLowerT;
      5: return ChLowerR;
      6: return ChLowerB;
      default: return ChLowerF;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send(input logic f, input logic [ByteW-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_seq(input string s);
    for (int i = 0; i < s.len(); i++) send(1'b0, s[i]);
  endtask

  // top count digits of cp as hex text, random case, optionally with junk characters
  task automatic send_hex(input logic [15:0] cp, input int count, input bit noisy);
    logic [3:0]       nib;
    logic [ByteW-1:0] ch;
    for (int i = 0; i < count; i++) begin
      nib = cp[15-4*i -: 4];
      if (nib < 4'd10) ch = 8'(8'h30 + nib);
      else ch = 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 4'd10);
      if (noisy && $urandom_range(0, 3) == 0) ch = 8'($urandom);
      send(1'b0, ch);
    end
  endtask

  task automatic send_string();
    int               n;
    int               r;
    logic [ByteW-1:0] b;
    logic [15:0]      cp;
    n = $urandom_range(0, 10);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        b = 8'($urandom);
        if (b == ChQuote || b == ChBackslash) b ^= 8'h01;
        send(1'b0, b);
      end else if (r < 70) begin
        send(1'b0, ChBackslash);
        send(1'b0, esc_char($urandom_range(0, 7)));
      end else if (r < 92) begin
        case ($urandom_range(0, 2))
          0: cp = 16'($urandom_range(0, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          default: cp = 16'($urandom);
        endcase
        send(1'b0, ChBackslash);
        send(1'b0, ChLowerU);
        send_hex(cp, 4, $urandom_range(0, 9) == 0);
      end else begin
        send(1'b0, ChBackslash);
        send(1'b0, 8'($urandom));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 80) begin
      send(1'b0, ChQuote);
    end else if (r < 87) begin
      send(1'b0, ChBackslash);
      send(1'b1, 8'($urandom));
    end else if (r < 94) begin
      send(1'b0, ChBackslash);
      send(1'b0, ChLowerU);
      send_hex(16'($urandom), $urandom_range(0, 3), 1'b0);
      send(1'b1, 8'($urandom));
    end else begin
      send(1'b1, 8'($urandom));
    end
    strings_sent++;
  endtask

  initial begin
    int n;
    res_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        res_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (res_valid && res_ready)) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    func         = 1'b0;
    in_byte      = '0;
    calm         = 1'b0;
    words_sent   = 0;
    strings_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(1'b0, 8'h00);
    send(1'b0, 8'hFF);
    send_seq("\\ux0g0\\uFfFf\\u04A9\\q\"");
    send_seq("\\u7");
    send(1'b1, 8'hA5);
    send_seq("\\");
    send(1'b1, 8'h5A);
    send(1'b1, 8'hFF);
    directed_words = words_sent;

    while (words_sent < directed_words + RandomWords) begin
      if ($urandom_range(0, 4) == 0) calm = ~calm;
      send_string();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Covered %0d random strings in %0d input words (%0d directed), gaps on both sides.",
             strings_sent, words_sent, directed_words);
    $display("Checked %0d result words, %0d mismatches.", results, errors);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_outq.sv
hw/rtl/json_string_unescape.sv
hw/rtl/jsu_checker.sv
tb/jsu_checker.sv
tb/testbench.sv
